[sv/plhd_pkg.sv]
// Shared types, byte codes and address helpers for the pixel lane hit decoder.
package plhd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int ADDR_W = 23;
  localparam int MASK_W = 8;
  localparam int OFS_W  = $clog2(MASK_W);
  localparam int HIT_W  = 16;

  localparam logic [7:0] MASK_TOP2    = 8'hC0;
  localparam logic [7:0] MASK_TOP3    = 8'hE0;
  localparam logic [7:0] MASK_NIB     = 8'hF0;
  localparam logic [7:0] SHORT_CODE   = 8'h40;
  localparam logic [7:0] LONG_CODE    = 8'h00;
  localparam logic [7:0] REGION_CODE  = 8'hC0;
  localparam logic [7:0] TRAILER_CODE = 8'hB0;
  localparam logic [7:0] EMPTY_CODE   = 8'hE0;

  typedef enum logic [1:0] {
    KIND_HIT   = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } plhd_kind_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              stat;
    plhd_kind_t        kind;
    logic [7:0]        bad;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        bunch;
    logic [HIT_W-1:0]  count;
  } plhd_cmd_t;

  function automatic logic [13:0] hit_x(input logic [ADDR_W-1:0] addr);
    return {addr[22:10], addr[0] ^ addr[1]};
  endfunction

  function automatic logic [8:0] hit_y(input logic [ADDR_W-1:0] addr);
    return addr[9:1];
  endfunction

endpackage

[sv/pixel_lane_hit_decoder_core.sv]
// Top level of the pixel lane hit decoder: front parser, word queue, result expander.
//
//  channel | dir | tdata (low bit up)                          | tuser | tlast
//  s_*     | in  | data_byte[7:0]                              | first | last
//  m_*     | out | pixel_x, pixel_y, bunch_counter, hit_count, | kind  | last_result
//          |     | bad_byte, pad                               |       |
//
// The front takes one byte per cycle while the 4-word queue has room.
// The back gives one result per cycle while m_tready allows; a data long third byte
// yields up to eight results (seven hits and event done), set by the hit expander.
// Reset clears parse state, queue pointers and output valid.
// A stall on m_tready holds the output word; the queue then fills and drops s_tready.
module pixel_lane_hit_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tuser,   // first
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pixel_x[13:0], pixel_y[22:14], bunch_counter[30:23],
                                 // hit_count[46:31], bad_byte[54:47], zero[55]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);

  plhd_pkg::plhd_cmd_t push_cmd, head;
  logic push, q_ready, q_valid, pop;

  plhd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .data_byte (s_tdata),
    .first     (s_tuser),
    .last      (s_tlast),
    .q_ready   (q_ready),
    .cmd_push  (push),
    .cmd       (push_cmd)
  );

  plhd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .valid    (q_valid),
    .head     (head),
    .pop      (pop)
  );

  plhd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[sv/plhd_front.sv]
// Front end: parses lane bytes and issues hit and status words to the queue.
module plhd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                first,
  input  logic                last,
  input  logic                q_ready,
  output logic                cmd_push,
  output plhd_pkg::plhd_cmd_t cmd
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_BUNCH, PH_EBUNCH, PH_WORD, PH_SHORT2, PH_LONG2, PH_LONG3, PH_DONE
  } phase_t;

  phase_t       phase, phase_next;
  logic [3:0]   chip_id, chip_id_next;
  logic [4:0]   region, region_next;
  logic [7:0]   held_byte, held_byte_next;
  logic [13:0]  long_address, long_address_next;
  logic [plhd_pkg::HIT_W-1:0] hits_so_far, hits_so_far_next;
  logic [7:0]   bunch_reg, bunch_reg_next;
  logic         push_c;
  logic         empty;
  logic         accept;
  logic [plhd_pkg::HIT_W:0] hit_sum;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign cmd_push = accept && push_c;

  always_comb begin
    phase_next        = phase;
    chip_id_next      = chip_id;
    region_next       = region;
    held_byte_next    = held_byte;
    long_address_next = long_address;
    hits_so_far_next  = hits_so_far;
    bunch_reg_next    = bunch_reg;
    push_c            = 1'b0;
    cmd               = '0;
    cmd.kind          = plhd_pkg::KIND_DONE;
    empty             = (data_byte & plhd_pkg::MASK_NIB) == plhd_pkg::EMPTY_CODE;
    hit_sum           = '0;
    if (first) begin
      chip_id_next      = data_byte[3:0];
      region_next       = '0;
      hits_so_far_next  = '0;
      bunch_reg_next    = '0;
      held_byte_next    = '0;
      long_address_next = '0;
      phase_next        = empty ? PH_EBUNCH : PH_BUNCH;
      if (last) begin
        push_c     = 1'b1;
        cmd.stat   = 1'b1;
        cmd.kind   = empty ? plhd_pkg::KIND_EMPTY : plhd_pkg::KIND_DONE;
        phase_next = PH_DONE;
      end
    end else begin
      unique case (phase)
        PH_BUNCH: begin
          bunch_reg_next = data_byte;
          phase_next     = PH_WORD;
        end
        PH_EBUNCH: begin
          bunch_reg_next = data_byte;
          push_c         = 1'b1;
          cmd.stat       = 1'b1;
          cmd.kind       = plhd_pkg::KIND_EMPTY;
          phase_next     = PH_DONE;
        end
        PH_WORD: begin
          if ((data_byte & plhd_pkg::MASK_TOP2) == plhd_pkg::SHORT_CODE) begin
            held_byte_next = data_byte;
            phase_next     = PH_SHORT2;
          end else if ((data_byte & plhd_pkg::MASK_TOP2) == plhd_pkg::LONG_CODE) begin
            held_byte_next = data_byte;
            phase_next     = PH_LONG2;
          end else if ((data_byte & plhd_pkg::MASK_TOP3) == plhd_pkg::REGION_CODE) begin
            region_next = data_byte[4:0];
          end else if ((data_byte & plhd_pkg::MASK_NIB) == plhd_pkg::TRAILER_CODE) begin
            push_c     = 1'b1;
            cmd.stat   = 1'b1;
            cmd.kind   = plhd_pkg::KIND_DONE;
            phase_next = PH_DONE;
          end else begin
            push_c     = 1'b1;
            cmd.stat   = 1'b1;
            cmd.kind   = plhd_pkg::KIND_ERROR;
            cmd.bad    = data_byte;
            phase_next = PH_DONE;
          end
        end
        PH_SHORT2: begin
          push_c     = 1'b1;
          cmd.mask   = plhd_pkg::MASK_W'(1);
          cmd.addr   = {chip_id, region, held_byte[5:0], data_byte};
          phase_next = PH_WORD;
        end
        PH_LONG2: begin
          if (!last) begin
            long_address_next = {held_byte[5:0], data_byte};
            push_c            = 1'b1;
            cmd.mask          = plhd_pkg::MASK_W'(1);
            cmd.addr          = {chip_id, region, held_byte[5:0], data_byte};
            phase_next        = PH_LONG3;
          end
        end
        PH_LONG3: begin
          push_c     = |data_byte[6:0];
          cmd.mask   = {data_byte[6:0], 1'b0};
          cmd.addr   = {chip_id, region, long_address};
          phase_next = PH_WORD;
        end
        PH_IDLE, PH_DONE: begin
        end
      endcase
      if (last && phase_next != PH_DONE && phase_next != PH_IDLE) begin
        push_c     = 1'b1;
        cmd.stat   = 1'b1;
        cmd.kind   = plhd_pkg::KIND_DONE;
        phase_next = PH_DONE;
      end
      hit_sum          = {1'b0, hits_so_far} + (plhd_pkg::HIT_W + 1)'($countones(cmd.mask));
      hits_so_far_next = hit_sum[plhd_pkg::HIT_W] ? '1 : hit_sum[plhd_pkg::HIT_W-1:0];
    end
    cmd.bunch = bunch_reg_next;
    cmd.count = first ? '0 : hits_so_far;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      chip_id      <= '0;
      region       <= '0;
      held_byte    <= '0;
      long_address <= '0;
      hits_so_far  <= '0;
      bunch_reg    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      chip_id      <= chip_id_next;
      region       <= region_next;
      held_byte    <= held_byte_next;
      long_address <= long_address_next;
      hits_so_far  <= hits_so_far_next;
      bunch_reg    <= bunch_reg_next;
    end
  end

endmodule

[sv/plhd_queue.sv]
// Short register queue of decoded words between front and back end.
module plhd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  plhd_pkg::plhd_cmd_t push_cmd,
  output logic                ready,
  output logic                valid,
  output plhd_pkg::plhd_cmd_t head,
  input  logic                pop
);

  plhd_pkg::plhd_cmd_t mem [plhd_pkg::QDEPTH];
  logic [plhd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [plhd_pkg::QCNT_W-1:0] fill;

  assign ready = fill != plhd_pkg::QCNT_W'(plhd_pkg::QDEPTH);
  assign valid = fill != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == plhd_pkg::QPTR_W'(plhd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == plhd_pkg::QPTR_W'(plhd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

[sv/plhd_back.sv]
// Back end: expands queued words into hit and status results, one per cycle unless m_tready stalls.
module plhd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  plhd_pkg::plhd_cmd_t q_cmd,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);

  plhd_pkg::plhd_cmd_t cur;
  logic cur_valid;
  logic step, finish, is_hit, stat_after, end_of_word;
  logic [plhd_pkg::OFS_W-1:0]  ofs;
  logic [plhd_pkg::MASK_W-1:0] mask_after;
  logic [plhd_pkg::HIT_W-1:0]  count_after;
  logic [plhd_pkg::ADDR_W-1:0] hit_addr;

  always_comb begin
    ofs = '0;
    for (int i = plhd_pkg::MASK_W - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        ofs = plhd_pkg::OFS_W'(i);
      end
    end
  end

  assign step        = cur_valid && (!m_tvalid || m_tready);
  assign is_hit      = |cur.mask;
  assign mask_after  = cur.mask & ~(plhd_pkg::MASK_W'(1) << ofs);
  assign stat_after  = is_hit ? cur.stat : 1'b0;
  assign count_after = !is_hit ? cur.count :
                       (&cur.count) ? cur.count : cur.count + 1'b1;
  assign hit_addr    = cur.addr + plhd_pkg::ADDR_W'(ofs);
  assign end_of_word = (mask_after == '0) && !stat_after;
  assign finish      = step && end_of_word;
  assign q_pop       = q_valid && (!cur_valid || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end else if (step) begin
      cur.mask  <= mask_after;
      cur.stat  <= stat_after;
      cur.count <= count_after;
    end
    if (step) begin
      m_tuser              <= is_hit ? plhd_pkg::KIND_HIT : cur.kind;
      m_tdata[13:0]        <= is_hit ? plhd_pkg::hit_x(hit_addr) : 14'd0;
      m_tdata[22:14]       <= is_hit ? plhd_pkg::hit_y(hit_addr) : 9'd0;
      m_tdata[30:23]       <= cur.bunch;
      m_tdata[46:31]       <= count_after;
      m_tdata[54:47]       <= is_hit ? 8'd0 : cur.bad;
      m_tdata[55]          <= 1'b0;
      m_tlast              <= end_of_word;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking stream testbench for the pixel lane hit decoder core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned RANDOM_BYTES = 72;
  localparam logic [7:0] ERR_BASE = 8'h80;
  localparam int unsigned COL_MASK = 32'h0000_FFFE;
  localparam int unsigned ROW_MASK = 32'h0000_01FF;

  typedef enum logic [2:0] {
    LP_IDLE, LP_BUNCH, LP_EBUNCH, LP_WORD, LP_SHORT2, LP_LONG2, LP_LONG3, LP_CLOSED
  } lane_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fst;
    logic       lst;
  } lane_byte_t;

  typedef struct {
    plhd_pkg::plhd_kind_t kind;
    logic [13:0] x;
    logic [8:0]  y;
    logic [7:0]  bunch;
    logic [15:0] count;
    logic [7:0]  bad;
    logic        tail;
  } lane_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  lane_byte_t   pending_bytes[$];
  lane_result_t expected_words[$];

  lane_phase_t lane_phase = LP_IDLE;
  logic [3:0]  cur_chip = '0;
  logic [4:0]  cur_region = '0;
  logic [7:0]  first_half = '0;
  logic [13:0] long_base = '0;
  logic [15:0] event_hits = '0;
  logic [7:0]  cur_bunch = '0;

  bit          busy = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned reports = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned hits_checked = 0;
  int unsigned events_seen = 0;
  int unsigned random_bytes = 0;

  pixel_lane_hit_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned chip_prefix();
    return (int'(cur_chip) << 19) | (int'(cur_region) << 14);
  endfunction

  task automatic push_status(input plhd_pkg::plhd_kind_t kind, input logic [7:0] bad);
    lane_result_t r;
    r.kind  = kind;
    r.x     = '0;
    r.y     = '0;
    r.bunch = cur_bunch;
    r.count = event_hits;
    r.bad   = bad;
    r.tail  = 1'b0;
    expected_words.push_back(r);
  endtask

  task automatic push_hit(input int unsigned addr);
    lane_result_t r;
    if (event_hits != 16'hFFFF) event_hits++;
    r.kind  = plhd_pkg::KIND_HIT;
    r.x     = 14'(((addr >> 9) & COL_MASK) | ((addr ^ (addr >> 1)) & 1));
    r.y     = 9'((addr >> 1) & ROW_MASK);
    r.bunch = cur_bunch;
    r.count = event_hits;
    r.bad   = '0;
    r.tail  = 1'b0;
    expected_words.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fst, input logic lst);
    int unsigned n0;
    logic empty;
    n0 = expected_words.size();
    if (fst) begin
      empty = (b & plhd_pkg::MASK_NIB) == plhd_pkg::EMPTY_CODE;
      cur_chip = b[3:0];
      cur_region = '0;
      event_hits = '0;
      cur_bunch = '0;
      first_half = '0;
      long_base = '0;
      events_seen++;
      lane_phase = empty ? LP_EBUNCH : LP_BUNCH;
      if (lst) begin
        push_status(empty ? plhd_pkg::KIND_EMPTY : plhd_pkg::KIND_DONE, 8'h00);
        lane_phase = LP_CLOSED;
      end
    end else begin
      case (lane_phase)
        LP_BUNCH: begin
          cur_bunch = b;
          lane_phase = LP_WORD;
        end
        LP_EBUNCH: begin
          cur_bunch = b;
          push_status(plhd_pkg::KIND_EMPTY, 8'h00);
          lane_phase = LP_CLOSED;
        end
        LP_WORD: begin
          if ((b & plhd_pkg::MASK_TOP2) == plhd_pkg::SHORT_CODE) begin
            first_half = b;
            lane_phase = LP_SHORT2;
          end else if ((b & plhd_pkg::MASK_TOP2) == plhd_pkg::LONG_CODE) begin
            first_half = b;
            lane_phase = LP_LONG2;
          end else if ((b & plhd_pkg::MASK_TOP3) == plhd_pkg::REGION_CODE) begin
            cur_region = b[4:0];
          end else if ((b & plhd_pkg::MASK_NIB) == plhd_pkg::TRAILER_CODE) begin
            push_status(plhd_pkg::KIND_DONE, 8'h00);
            lane_phase = LP_CLOSED;
          end else begin
            push_status(plhd_pkg::KIND_ERROR, b);
            lane_phase = LP_CLOSED;
          end
        end
        LP_SHORT2: begin
          push_hit(chip_prefix() | int'({first_half[5:0], b}));
          lane_phase = LP_WORD;
        end
        LP_LONG2: begin
          if (!lst) begin
            long_base = {first_half[5:0], b};
            push_hit(chip_prefix() | int'(long_base));
            lane_phase = LP_LONG3;
          end
        end
        LP_LONG3: begin
          for (int k = 0; k < 7; k++)
            if (b[k]) push_hit((chip_prefix() | int'(long_base)) + k + 1);
          lane_phase = LP_WORD;
        end
        default: ;
      endcase
      if (lst && lane_phase != LP_CLOSED && lane_phase != LP_IDLE) begin
        push_status(plhd_pkg::KIND_DONE, 8'h00);
        lane_phase = LP_CLOSED;
      end
    end
    if (expected_words.size() > n0) expected_words[expected_words.size() - 1].tail = 1'b1;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  task automatic check_word();
    lane_result_t want;
    if (expected_words.size() == 0) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t ns: unexpected word, expected none, got tuser %0h tdata %0h",
                 $time, m_tuser, m_tdata);
      end
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (want.kind == plhd_pkg::KIND_HIT) hits_checked++;
    compare_field("kind", want.kind, m_tuser);
    compare_field("pixel_x", want.x, m_tdata[13:0]);
    compare_field("pixel_y", want.y, m_tdata[22:14]);
    compare_field("bunch_counter", want.bunch, m_tdata[30:23]);
    compare_field("hit_count", want.count, m_tdata[46:31]);
    compare_field("bad_byte", want.bad, m_tdata[54:47]);
    compare_field("last_result", want.tail, m_tlast);
  endtask

  task automatic put(input logic [7:0] b, input logic fst, input logic lst);
    pending_bytes.push_back('{b, fst, lst});
  endtask

  function automatic logic [7:0] bad_code();
    if ($urandom_range(0, 1) == 0) return ERR_BASE + 8'($urandom_range(0, 47));
    return plhd_pkg::EMPTY_CODE | 8'($urandom_range(0, 31));
  endfunction

  task automatic add_random_event();
    lane_byte_t ev[$];
    logic [7:0] hdr;
    int unsigned cut;
    hdr = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) == 0) hdr = plhd_pkg::EMPTY_CODE | 8'($urandom_range(0, 15));
    ev.push_back('{hdr, 1'b1, 1'b0});
    ev.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 3))
        0: ev.push_back('{plhd_pkg::REGION_CODE | 8'($urandom_range(0, 31)), 1'b0, 1'b0});
        1: begin
          ev.push_back('{plhd_pkg::SHORT_CODE | 8'($urandom_range(0, 63)), 1'b0, 1'b0});
          ev.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
        end
        default: begin
          ev.push_back('{plhd_pkg::LONG_CODE | 8'($urandom_range(0, 63)), 1'b0, 1'b0});
          ev.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
          ev.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        ev.push_back('{plhd_pkg::TRAILER_CODE | 8'($urandom_range(0, 15)), 1'b0,
                       1'($urandom_range(0, 4) == 0)});
      6: ev.push_back('{bad_code(), 1'b0, 1'($urandom_range(0, 4) == 0)});
      7, 8: begin
        cut = $urandom_range(0, ev.size() - 1);
        while (ev.size() > cut + 1) void'(ev.pop_back());
        ev[cut].lst = 1'b1;
      end
      default: ;
    endcase
    random_bytes += ev.size();
    foreach (ev[i]) pending_bytes.push_back(ev[i]);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // sender: bursts with gaps, hold each word until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!busy) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_bytes[0].b;
        s_tuser  <= pending_bytes[0].fst;
        s_tlast  <= pending_bytes[0].lst;
        busy = 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between free, light and heavy stalls
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(8, 64);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tuser, s_tlast);
        void'(pending_bytes.pop_front());
        busy = 1'b0;
        bytes_sent++;
      end
      if (m_tvalid && m_tready) check_word();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, expected_words.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // directed: ignored idle byte, full event with carry, empty chip, error,
    // header-only events, dropped open event and a cut data long
    put(8'h55, 1'b0, 1'b0);
    put(8'h05, 1'b1, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(plhd_pkg::REGION_CODE | 8'h1F, 1'b0, 1'b0);
    put(plhd_pkg::SHORT_CODE | 8'h3F, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(plhd_pkg::LONG_CODE | 8'h3F, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(plhd_pkg::TRAILER_CODE | 8'h03, 1'b0, 1'b0);
    put(8'h12, 1'b0, 1'b0);
    put(plhd_pkg::EMPTY_CODE | 8'h07, 1'b1, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(plhd_pkg::SHORT_CODE | 8'h04, 1'b0, 1'b0);
    put(8'h1F, 1'b1, 1'b0);
    put(8'h80, 1'b0, 1'b0);
    put(plhd_pkg::LONG_CODE, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h81, 1'b0, 1'b0);
    put(ERR_BASE, 1'b0, 1'b0);
    put(8'h2A, 1'b1, 1'b1);
    put(plhd_pkg::EMPTY_CODE | 8'h01, 1'b1, 1'b1);
    put(8'h33, 1'b1, 1'b0);
    put(8'h01, 1'b0, 1'b0);
    put(plhd_pkg::SHORT_CODE, 1'b0, 1'b0);
    put(8'h34, 1'b1, 1'b0);
    put(8'h02, 1'b0, 1'b0);
    put(plhd_pkg::LONG_CODE | 8'h12, 1'b0, 1'b0);
    put(8'h34, 1'b0, 1'b1);

    while (random_bytes < RANDOM_BYTES) add_random_event();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_bytes.size() != 0 || busy) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_words.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected words never arrived", $time, expected_words.size());
    end
    $display("Sent %0d lane bytes over %0d events, checked %0d result words (%0d hits).",
             bytes_sent, events_seen, words_checked, hits_checked);
    $display("Included empty chips, errors, cut words, dropped events and address carry.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/plhd_pkg.sv
sv/plhd_front.sv
sv/plhd_queue.sv
sv/plhd_back.sv
sv/pixel_lane_hit_decoder_core.sv
tb/tb.sv
